// ===== rtl/smqe_pkg.sv =====
// ----------------------------------------------------------------------------
// smqe_pkg
// Shared types and constants for the sorted multiset query engine.
// ----------------------------------------------------------------------------
package smqe_pkg;

  localparam int CAPACITY     = 64;
  localparam int RESULT_LIMIT = 64;
  localparam int AW           = $clog2(CAPACITY);
  localparam int CW           = $clog2(CAPACITY + 1);
  localparam int RW           = $clog2(RESULT_LIMIT + 1);
  localparam int VAL_W        = 32;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 7;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_RUN    = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    OP_SORT    = 2'd0,
    OP_MODE    = 2'd1,
    OP_CLOSEST = 2'd2,
    OP_FIRST_K = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_TOO_FEW  = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OP_SELECT   = 1'b0,
    CFG_FIRST_LIMIT = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_STATUS,
    S_INS_RD,
    S_INS_CHK,
    S_SH_RD,
    S_SH_WR,
    S_INS_NEW,
    S_SORT_RD,
    S_SORT_EMIT,
    S_MODE_RD,
    S_MODE_CHK,
    S_MODE_EMIT,
    S_CP_RD,
    S_CP_CHK,
    S_CP_LO,
    S_CP_HI
  } state_e;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [VAL_W-1:0] value;
  } smqe_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value_res;
    logic                    last;
    logic [1:0]              status;
  } smqe_out_t;

  // one table entry: distinct value and its occurrence count
  typedef struct packed {
    logic [VAL_W-1:0] val;
    logic [CW-1:0]    cnt;
  } entry_t;

endpackage

// ===== rtl/sorted_multiset_query_engine_core.sv =====
// ----------------------------------------------------------------------------
// sorted_multiset_query_engine_core
// Multiset of signed 32-bit integers kept as a sorted table of distinct
// values with counts, with sort, mode, closest pair and first-k queries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o, in_item_i): insert, run or clear.
//   Output channel (out_valid_o/out_ready_i, out_item_o): result items, the
//   final one of each answer marked by last. Config channel (cfg_*) writes
//   op_select and first_limit; ready is always high.
//   One item is worked on at a time; in_ready_o is high only when idle.
//   The table lives in a single-port-read, single-port-write RAM with a
//   registered read, so each entry visited takes a read state and a check
//   state. Busy time after the accepting edge, with the next item taken in idle:
//     insert: scan to the match or the first larger entry, then for a new
//     value shift the entries above up one and write it; clear: none;
//     run: mode and closest pair read every distinct value, then emit;
//     sort/first-k: one read per distinct value visited, one emit per item.
//   Results go through an output register, so a finished answer may wait
//   while the next item is accepted. A stalled receiver holds the engine
//   at its next emit until the register frees.
//   Reset empties the table at once (counts cleared, no RAM sweep) and sets
//   op_select to sort and first_limit to 1.
// ----------------------------------------------------------------------------
module sorted_multiset_query_engine_core
  import smqe_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  smqe_in_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output smqe_out_t             out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  state_e                  state_q, state_d;
  logic [CW-1:0]           distinct_q, distinct_d;
  logic [CW-1:0]           total_q, total_d;
  logic [CW-1:0]           idx_q, idx_d;
  logic [CW-1:0]           sh_q, sh_d;
  logic [CW-1:0]           copy_q, copy_d;
  logic [RW-1:0]           n_q, n_d;
  logic [RW-1:0]           limit_q, limit_d;
  logic [VAL_W-1:0]        val_q, val_d;
  logic [VAL_W-1:0]        lo_q, lo_d;
  logic [VAL_W-1:0]        hi_q, hi_d;
  logic [VAL_W-1:0]        prev_q, prev_d;
  logic [CW-1:0]           best_cnt_q, best_cnt_d;
  logic signed [VAL_W:0]   best_gap_q, best_gap_d;
  status_e                 stat_q, stat_d;
  logic [1:0]              op_q;
  logic [CFG_DATA_W-1:0]   flim_q;
  logic                    out_valid_q, out_valid_d;
  smqe_out_t               out_q, out_d;

  // table RAM
  entry_t                  tbl_mem [CAPACITY];
  entry_t                  rd_data_q;
  logic                    rd_en, wr_en;
  logic [AW-1:0]           rd_addr, wr_addr;
  entry_t                  wr_data;

  logic                    in_acc, can_emit, emit, sort_last;
  smqe_out_t               emit_item;
  logic signed [VAL_W:0]   gap;
  logic [RW-1:0]           k_clamped;
  logic [CW-1:0]           sh_dec;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign can_emit    = !out_valid_q || out_ready_i;
  assign sh_dec      = sh_q - CW'(1);

  assign gap = $signed({rd_data_q.val[VAL_W-1], rd_data_q.val})
             - $signed({prev_q[VAL_W-1], prev_q});

  assign sort_last = (n_q == limit_q - RW'(1))
                  || ((copy_q == rd_data_q.cnt - CW'(1)) && (idx_q == distinct_q - CW'(1)));

  always_comb begin
    if (flim_q == '0) begin
      k_clamped = RW'(1);
    end else if (32'(flim_q) > RESULT_LIMIT) begin
      k_clamped = RW'(RESULT_LIMIT);
    end else begin
      k_clamped = RW'(flim_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tbl_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= tbl_mem[rd_addr];
    end
  end

  always_comb begin
    state_d    = state_q;
    distinct_d = distinct_q;
    total_d    = total_q;
    idx_d      = idx_q;
    sh_d       = sh_q;
    copy_d     = copy_q;
    n_d        = n_q;
    limit_d    = limit_q;
    val_d      = val_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    prev_d     = prev_q;
    best_cnt_d = best_cnt_q;
    best_gap_d = best_gap_q;
    stat_d     = stat_q;
    rd_en      = 1'b0;
    rd_addr    = idx_q[AW-1:0];
    wr_en      = 1'b0;
    wr_addr    = idx_q[AW-1:0];
    wr_data    = rd_data_q;
    emit       = 1'b0;
    emit_item  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_item_i.req_type)
            REQ_INSERT: begin
              if (total_q >= CW'(CAPACITY)) begin
                stat_d  = ST_OVERFLOW;
                state_d = S_STATUS;
              end else begin
                val_d   = in_item_i.value;
                idx_d   = '0;
                state_d = S_INS_RD;
              end
            end
            REQ_CLEAR: begin
              distinct_d = '0;
              total_d    = '0;
            end
            REQ_RUN: begin
              idx_d      = '0;
              copy_d     = '0;
              n_d        = '0;
              best_cnt_d = '0;
              unique case (op_e'(op_q))
                OP_SORT, OP_FIRST_K: begin
                  limit_d = (op_e'(op_q) == OP_SORT) ? RW'(RESULT_LIMIT) : k_clamped;
                  if (total_q == '0) begin
                    stat_d  = ST_TOO_FEW;
                    state_d = S_STATUS;
                  end else begin
                    state_d = S_SORT_RD;
                  end
                end
                OP_MODE: begin
                  if (distinct_q == '0) begin
                    stat_d  = ST_TOO_FEW;
                    state_d = S_STATUS;
                  end else begin
                    state_d = S_MODE_RD;
                  end
                end
                OP_CLOSEST: begin
                  if (distinct_q < CW'(2)) begin
                    stat_d  = ST_TOO_FEW;
                    state_d = S_STATUS;
                  end else begin
                    state_d = S_CP_RD;
                  end
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      end

      S_STATUS: begin
        if (can_emit) begin
          emit             = 1'b1;
          emit_item.last   = 1'b1;
          emit_item.status = stat_q;
          state_d          = S_IDLE;
        end
      end

      S_INS_RD: begin
        if (idx_q == distinct_q) begin
          if (distinct_q >= CW'(CAPACITY)) begin
            stat_d  = ST_OVERFLOW;
            state_d = S_STATUS;
          end else begin
            sh_d    = distinct_q;
            state_d = S_SH_RD;
          end
        end else begin
          rd_en   = 1'b1;
          state_d = S_INS_CHK;
        end
      end

      S_INS_CHK: begin
        if ($signed(rd_data_q.val) < $signed(val_q)) begin
          idx_d   = idx_q + CW'(1);
          state_d = S_INS_RD;
        end else if (rd_data_q.val == val_q) begin
          wr_en       = 1'b1;
          wr_data.cnt = rd_data_q.cnt + CW'(1);
          total_d     = total_q + CW'(1);
          state_d     = S_IDLE;
        end else if (distinct_q >= CW'(CAPACITY)) begin
          stat_d  = ST_OVERFLOW;
          state_d = S_STATUS;
        end else begin
          sh_d    = distinct_q;
          state_d = S_SH_RD;
        end
      end

      // open a hole at idx_q by moving entries up one, top first
      S_SH_RD: begin
        if (sh_q > idx_q) begin
          rd_en   = 1'b1;
          rd_addr = sh_dec[AW-1:0];
          state_d = S_SH_WR;
        end else begin
          state_d = S_INS_NEW;
        end
      end

      S_SH_WR: begin
        wr_en   = 1'b1;
        wr_addr = sh_q[AW-1:0];
        sh_d    = sh_dec;
        state_d = S_SH_RD;
      end

      S_INS_NEW: begin
        wr_en       = 1'b1;
        wr_data.val = val_q;
        wr_data.cnt = CW'(1);
        distinct_d  = distinct_q + CW'(1);
        total_d     = total_q + CW'(1);
        state_d     = S_IDLE;
      end

      S_SORT_RD: begin
        rd_en   = 1'b1;
        copy_d  = '0;
        state_d = S_SORT_EMIT;
      end

      S_SORT_EMIT: begin
        if (can_emit) begin
          emit                = 1'b1;
          emit_item.value_res = rd_data_q.val;
          emit_item.last      = sort_last;
          n_d                 = n_q + RW'(1);
          if (sort_last) begin
            state_d = S_IDLE;
          end else if (copy_q == rd_data_q.cnt - CW'(1)) begin
            idx_d   = idx_q + CW'(1);
            state_d = S_SORT_RD;
          end else begin
            copy_d = copy_q + CW'(1);
          end
        end
      end

      S_MODE_RD: begin
        if (idx_q == distinct_q) begin
          state_d = S_MODE_EMIT;
        end else begin
          rd_en   = 1'b1;
          state_d = S_MODE_CHK;
        end
      end

      S_MODE_CHK: begin
        // strict compare keeps the smallest value on ties
        if (rd_data_q.cnt > best_cnt_q) begin
          best_cnt_d = rd_data_q.cnt;
          lo_d       = rd_data_q.val;
        end
        idx_d   = idx_q + CW'(1);
        state_d = S_MODE_RD;
      end

      S_MODE_EMIT: begin
        if (can_emit) begin
          emit                = 1'b1;
          emit_item.value_res = lo_q;
          emit_item.last      = 1'b1;
          state_d             = S_IDLE;
        end
      end

      S_CP_RD: begin
        if (idx_q == distinct_q) begin
          state_d = S_CP_LO;
        end else begin
          rd_en   = 1'b1;
          state_d = S_CP_CHK;
        end
      end

      S_CP_CHK: begin
        if (idx_q != '0) begin
          if ((idx_q == CW'(1)) || (gap < best_gap_q)) begin
            best_gap_d = gap;
            lo_d       = prev_q;
            hi_d       = rd_data_q.val;
          end
        end
        prev_d  = rd_data_q.val;
        idx_d   = idx_q + CW'(1);
        state_d = S_CP_RD;
      end

      S_CP_LO: begin
        if (can_emit) begin
          emit                = 1'b1;
          emit_item.value_res = lo_q;
          state_d             = S_CP_HI;
        end
      end

      S_CP_HI: begin
        if (can_emit) begin
          emit                = 1'b1;
          emit_item.value_res = hi_q;
          emit_item.last      = 1'b1;
          state_d             = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = emit_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      distinct_q  <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      op_q        <= OP_SORT;
      flim_q      <= CFG_DATA_W'(1);
    end else begin
      state_q     <= state_d;
      distinct_q  <= distinct_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_OP_SELECT:   op_q   <= cfg_data_i[1:0];
          CFG_FIRST_LIMIT: flim_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    sh_q       <= sh_d;
    copy_q     <= copy_d;
    n_q        <= n_d;
    limit_q    <= limit_d;
    val_q      <= val_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    prev_q     <= prev_d;
    best_cnt_q <= best_cnt_d;
    best_gap_q <= best_gap_d;
    stat_q     <= stat_d;
    out_q      <= out_d;
  end

  // RAM never sees a read and a write of the same entry in one cycle
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("table read and write collide");

  a_counts_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (distinct_q <= total_q) && (total_q <= CW'(CAPACITY)))
    else $error("distinct/total counts inconsistent");

  a_emit_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_valid_q || out_ready_i))
    else $error("result emitted over a waiting item");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_item_i.req_type == REQ_CLEAR)) |=> (total_q == '0) && (distinct_q == '0))
    else $error("clear did not empty the table");

  a_no_accept_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && (state_q != S_STATUS)) |-> (state_q != S_IDLE) && !in_ready_o)
    else $error("item accepted while a run is in flight");

endmodule
